### hdl/ppfl_pkg.sv
// Shared types and constants for the pooled page free list.
package ppfl_pkg;

   localparam int PAGE_W      = 10;
   localparam int PAGE_SPACE  = 1 << PAGE_W;
   localparam int POOL_SHIFT  = 6;
   localparam int POOL_PAGES  = 1 << POOL_SHIFT;
   localparam int POOL_W      = PAGE_W - POOL_SHIFT;
   localparam int MAX_POOLS   = 16;
   localparam int POOL_FIT    = PAGE_SPACE / POOL_PAGES;
   localparam int POOL_LIMIT  = (MAX_POOLS < POOL_FIT) ? MAX_POOLS : POOL_FIT;
   localparam int CNT_IDX_W   = $clog2(MAX_POOLS);
   localparam int OPEN_W      = 5;
   localparam int USED_W      = 7;
   localparam logic [USED_W-1:0] USED_MAX = 7'd127;

   localparam logic CMD_POP  = 1'b0;
   localparam logic CMD_PUSH = 1'b1;

   // One entry of the link memory: valid flag and the next page.
   typedef struct packed {
      logic              valid;
      logic [PAGE_W-1:0] page;
   } link_type;

   // Link of a page that has not been rewritten since its pool was opened.
   function automatic link_type fresh_link(input logic [PAGE_W-1:0] page);
      link_type l;
      if (page[POOL_SHIFT-1:0] == POOL_SHIFT'(POOL_PAGES - 1)) begin
         l.valid = 1'b0;
         l.page  = '0;
      end else begin
         l.valid = 1'b1;
         l.page  = page + PAGE_W'(1);
      end
      return l;
   endfunction

endpackage

### hdl/ppfl_link_mem.sv
// Link memory of the free list: one write port, one registered read port.
module ppfl_link_mem
   import ppfl_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [PAGE_W-1:0] wr_addr,
   input  link_type          wr_data,
   input  logic              rd_en,
   input  logic [PAGE_W-1:0] rd_addr,
   output link_type          rd_data
);

   link_type mem [PAGE_SPACE];
   link_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/pooled_page_free_list.sv
// Top level of the pooled page free list page allocator.
//
// Usage: a request is presented on req_command and req_page_index with start
// held high; it is taken at the rising clock edge where start is high and busy
// is low. A pop (command 0) hands out the page at the head of the free list;
// when the list is empty and fewer than POOL_LIMIT pools are open, the next
// pool of POOL_PAGES consecutive pages is opened and its first page returned.
// A push (command 1) of a page of an open pool whose used count is not zero
// links it back at the head of the list and lowers that count. Every request
// produces exactly one response, registered from the request stage and
// marked by rsp_valid for one cycle. The receiver cannot stall the response
// channel, so each response must be taken as it appears. A request is not
// taken while the last one is in the request stage: the edge that takes a
// request also reads the link memory at the current head, the cycle after it
// computes the new head and updates the state, and busy holds off the edge
// that ends that cycle because the next request needs the new head for its
// own read. Newly opened pools are threaded lazily: a bit per page of the
// newest pool tells whether its link was rewritten, otherwise the link to
// the next page is implied, so opening a pool needs no pass over its links.
// Reset is synchronous and active high; it empties the list, closes all
// pools and clears the used counts. No clearing pass is needed after reset.
module pooled_page_free_list
   import ppfl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_command,
   input  logic [PAGE_W-1:0] req_page_index,
   output logic              rsp_valid,
   output logic [PAGE_W-1:0] rsp_page_index_res,
   output logic              rsp_ok,
   output logic [USED_W-1:0] rsp_pool_used,
   output logic [OPEN_W-1:0] rsp_pools_open
);

   // Request stage.
   logic              stage_valid_ff;
   logic              cmd_ff;
   logic [PAGE_W-1:0] page_ff;

   // Allocator state.
   logic [PAGE_W-1:0]     head_ff, head_in;
   logic                  head_valid_ff, head_valid_in;
   logic [OPEN_W-1:0]     open_pools_ff, open_pools_in;
   logic [USED_W-1:0]     used_ff [MAX_POOLS];
   logic [POOL_PAGES-1:0] written_ff, written_in;

   // Response registers.
   logic              rsp_valid_ff;
   logic [PAGE_W-1:0] rsp_page_ff, rsp_page_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [USED_W-1:0] rsp_used_ff, rsp_used_in;

   // Link memory interface.
   logic     accept;
   logic     mem_we;
   link_type mem_wdata;
   link_type mem_rdata;

   // Used count update.
   logic                 used_we;
   logic [CNT_IDX_W-1:0] used_idx;
   logic [USED_W-1:0]    used_cur;
   logic [USED_W-1:0]    used_new;

   // Intermediate values computed from the request stage.
   logic [PAGE_W-1:0] first_page;
   logic [PAGE_W-1:0] pop_page;
   logic [POOL_W-1:0] pop_pool;
   logic [POOL_W-1:0] push_pool;
   logic [OPEN_W-1:0] cur_pool;
   logic              head_in_cur;
   logic              push_in_cur;
   logic              can_open;
   link_type          next_link;
   logic [USED_W-1:0] used_base;

   assign accept = start && !busy;
   assign busy   = stage_valid_ff;

   ppfl_link_mem u_link_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (page_ff),
      .wr_data (mem_wdata),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (mem_rdata)
   );

   always_comb begin
      first_page  = {open_pools_ff[POOL_W-1:0], {POOL_SHIFT{1'b0}}};
      pop_page    = head_valid_ff ? head_ff : first_page;
      pop_pool    = pop_page[PAGE_W-1 -: POOL_W];
      push_pool   = page_ff[PAGE_W-1 -: POOL_W];
      cur_pool    = open_pools_ff - OPEN_W'(1);
      head_in_cur = (open_pools_ff != '0) && (OPEN_W'(head_ff[PAGE_W-1 -: POOL_W]) == cur_pool);
      push_in_cur = (open_pools_ff != '0) && (OPEN_W'(push_pool) == cur_pool);
      can_open    = open_pools_ff < OPEN_W'(POOL_LIMIT);

      used_idx = CNT_IDX_W'((cmd_ff == CMD_POP) ? pop_pool : push_pool);
      used_cur = used_ff[used_idx];

      // The head's link comes from memory unless the list is empty or the head
      // belongs to the newest pool and was never relinked since that pool was opened.
      if (head_valid_ff && !(head_in_cur && !written_ff[head_ff[POOL_SHIFT-1:0]])) begin
         next_link = mem_rdata;
      end else begin
         next_link = fresh_link(pop_page);
      end

      used_base = head_valid_ff ? used_cur : '0;

      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      open_pools_in = open_pools_ff;
      written_in    = written_ff;
      rsp_page_in   = '0;
      rsp_ok_in     = 1'b0;
      rsp_used_in   = '0;
      used_we       = 1'b0;
      used_new      = used_cur;
      mem_we        = 1'b0;
      mem_wdata.valid = head_valid_ff;
      mem_wdata.page  = head_valid_ff ? head_ff : '0;

      if (stage_valid_ff) begin
         if (cmd_ff == CMD_POP) begin
            if (head_valid_ff || can_open) begin
               if (!head_valid_ff) begin
                  open_pools_in = open_pools_ff + OPEN_W'(1);
                  written_in    = '0;
               end
               head_valid_in = next_link.valid;
               head_in       = next_link.valid ? next_link.page : '0;
               used_new      = (used_base == USED_MAX) ? used_base : used_base + USED_W'(1);
               used_we       = 1'b1;
               rsp_page_in   = pop_page;
               rsp_ok_in     = 1'b1;
               rsp_used_in   = used_new;
            end
         end else begin
            rsp_page_in = page_ff;
            if ((OPEN_W'(push_pool) < open_pools_ff) && (used_cur != '0)) begin
               used_new      = used_cur - USED_W'(1);
               used_we       = 1'b1;
               mem_we        = 1'b1;
               head_in       = page_ff;
               head_valid_in = 1'b1;
               if (push_in_cur) begin
                  written_in[page_ff[POOL_SHIFT-1:0]] = 1'b1;
               end
               rsp_ok_in   = 1'b1;
               rsp_used_in = used_new;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         head_ff        <= '0;
         head_valid_ff  <= 1'b0;
         open_pools_ff  <= '0;
         written_ff     <= '0;
         for (int i = 0; i < MAX_POOLS; i++) begin
            used_ff[i] <= '0;
         end
      end else begin
         stage_valid_ff <= accept;
         rsp_valid_ff   <= stage_valid_ff;
         head_ff        <= head_in;
         head_valid_ff  <= head_valid_in;
         open_pools_ff  <= open_pools_in;
         written_ff     <= written_in;
         if (used_we) begin
            used_ff[used_idx] <= used_new;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         page_ff <= req_page_index;
      end
      if (stage_valid_ff) begin
         rsp_page_ff <= rsp_page_in;
         rsp_ok_ff   <= rsp_ok_in;
         rsp_used_ff <= rsp_used_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_page_index_res = rsp_page_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_pool_used      = rsp_used_ff;
   assign rsp_pools_open     = open_pools_ff;

endmodule
